// ===== rtl/fcer_pkg.sv =====
// fcer_pkg: shared types, widths and constants of the comb echo / reverb core
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package fcer_pkg;

    // sample and config port widths
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MS_W      = 10;
    localparam int RATE_W    = 16;
    localparam int N_STAGES  = 3;

    // default history depth per comb stage
    localparam int unsigned MAX_DELAY_DEF = 8192;

    // ms * rate / 1000 through a reciprocal multiply, exact for 26-bit products
    localparam int PROD_W    = MS_W + RATE_W;
    localparam int RECIP_W   = 27;
    localparam int DIV_SHIFT = 36;
    localparam int QUOT_W    = PROD_W + RECIP_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;
    localparam int unsigned MS_PER_S = 1000;

    // register reset values
    localparam logic               MODE_RST     = 1'b0;
    localparam int unsigned        ECHO_MS_RST  = 50;
    localparam int unsigned        RATE_RST     = 44100;
    localparam logic signed [15:0] ECHO_GAIN_RST = 16'sd9830;

    // fixed reverb cascade: delays in ms and Q1.15 gains
    localparam int unsigned        REV_MS_1   = 50;
    localparam int unsigned        REV_MS_2   = 100;
    localparam int unsigned        REV_MS_3   = 150;
    localparam logic signed [15:0] REV_GAIN_1 = 16'sd9830;
    localparam logic signed [15:0] REV_GAIN_2 = 16'sd6554;
    localparam logic signed [15:0] REV_GAIN_3 = 16'sd3277;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_DELAY = 2'd1,
        CFG_RATE  = 2'd2,
        CFG_GAIN  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_ECHO   = 1'b0,
        MODE_REVERB = 1'b1
    } t_mode;

    // live configuration seen by the datapath
    typedef struct packed {
        t_mode                      mode;
        logic signed [SAMPLE_W-1:0] gain;
    } t_cfg;

    // per-stage decisions, fixed for a word when it enters the first comb
    typedef struct packed {
        logic bypass;   // position below delay, or stage unused in echo mode
        logic zero;     // delay of zero: feed back the stage input
        logic one;      // delay of one: take the previous word's output
    } t_flags;

    typedef struct packed {
        logic                   last;
        t_flags [N_STAGES-1:0]  flags;
    } t_tag;

endpackage

// ===== rtl/fcer_delay_unit.sv =====
// fcer_delay_unit: configuration registers and the ms-to-samples delay pipeline
// depends on fcer_pkg
`timescale 1ns / 1ps

module fcer_delay_unit #(
    parameter int unsigned MAX_DELAY = fcer_pkg::MAX_DELAY_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [fcer_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [fcer_pkg::CFG_W-1:0]               i_cfg_wdata,
    output fcer_pkg::t_cfg                           o_cfg,
    output logic [fcer_pkg::N_STAGES-1:0][$clog2(MAX_DELAY+1)-1:0] o_delay
);
    import fcer_pkg::*;

    localparam int DW = $clog2(MAX_DELAY + 1);
    localparam int FW = PROD_W + RECIP_W;

    localparam int unsigned P_RST_1 = ECHO_MS_RST * RATE_RST;
    localparam int unsigned P_RST_2 = REV_MS_2 * RATE_RST;
    localparam int unsigned P_RST_3 = REV_MS_3 * RATE_RST;
    localparam int unsigned D_RST_1 = (P_RST_1 / MS_PER_S > MAX_DELAY) ? MAX_DELAY
                                                                       : P_RST_1 / MS_PER_S;
    localparam int unsigned D_RST_2 = (P_RST_2 / MS_PER_S > MAX_DELAY) ? MAX_DELAY
                                                                       : P_RST_2 / MS_PER_S;
    localparam int unsigned D_RST_3 = (P_RST_3 / MS_PER_S > MAX_DELAY) ? MAX_DELAY
                                                                       : P_RST_3 / MS_PER_S;

    t_mode                      r_mode;
    logic [MS_W-1:0]            r_echo_ms;
    logic [RATE_W-1:0]          r_rate;
    logic signed [SAMPLE_W-1:0] r_gain;

    logic [N_STAGES-1:0][MS_W-1:0]   w_ms;
    logic [N_STAGES-1:0][PROD_W-1:0] r_prod;
    logic [N_STAGES-1:0][DW-1:0]     r_delay;
    logic [N_STAGES-1:0][FW-1:0]     w_full;
    logic [N_STAGES-1:0][QUOT_W-1:0] w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= t_mode'(MODE_RST);
            r_echo_ms <= MS_W'(ECHO_MS_RST);
            r_rate    <= RATE_W'(RATE_RST);
            r_gain    <= ECHO_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:  r_mode    <= t_mode'(i_cfg_wdata[0]);
                CFG_DELAY: r_echo_ms <= i_cfg_wdata[MS_W-1:0];
                CFG_RATE:  r_rate    <= i_cfg_wdata[RATE_W-1:0];
                CFG_GAIN:  r_gain    <= $signed(i_cfg_wdata[SAMPLE_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ms[0] = (r_mode == MODE_REVERB) ? MS_W'(REV_MS_1) : r_echo_ms;
        w_ms[1] = MS_W'(REV_MS_2);
        w_ms[2] = MS_W'(REV_MS_3);
        for (int k = 0; k < N_STAGES; k++) begin
            w_full[k] = FW'(r_prod[k]) * FW'(DIV_RECIP);
            w_quot[k] = w_full[k][DIV_SHIFT +: QUOT_W];
        end
    end

    // product registered in r_prod, then reciprocal multiply and clamp registered in r_delay
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod[0]  <= PROD_W'(P_RST_1);
            r_prod[1]  <= PROD_W'(P_RST_2);
            r_prod[2]  <= PROD_W'(P_RST_3);
            r_delay[0] <= DW'(D_RST_1);
            r_delay[1] <= DW'(D_RST_2);
            r_delay[2] <= DW'(D_RST_3);
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                r_prod[k]  <= PROD_W'(w_ms[k]) * PROD_W'(r_rate);
                r_delay[k] <= (w_quot[k] > QUOT_W'(MAX_DELAY)) ? DW'(MAX_DELAY)
                                                                 : w_quot[k][DW-1:0];
            end
        end
    end

    assign o_cfg.mode = r_mode;
    assign o_cfg.gain = r_gain;
    assign o_delay    = r_delay;

endmodule

// ===== rtl/fcer_comb_stage.sv =====
// fcer_comb_stage: one feedback comb with its own history memory
// depends on fcer_pkg; the read for a word is issued as it enters the stage
`timescale 1ns / 1ps

module fcer_comb_stage #(
    parameter int unsigned MAX_DELAY = fcer_pkg::MAX_DELAY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_vld,
    input  logic signed [fcer_pkg::SAMPLE_W-1:0] i_x,
    input  logic [$clog2(MAX_DELAY)-1:0]         i_wp,
    input  fcer_pkg::t_tag                       i_tag,
    input  fcer_pkg::t_flags                     i_flag,
    input  logic [$clog2(MAX_DELAY+1)-1:0]       i_delay,
    input  logic signed [fcer_pkg::SAMPLE_W-1:0] i_gain,
    output logic                                 o_vld,
    output logic signed [fcer_pkg::SAMPLE_W-1:0] o_y,
    output logic [$clog2(MAX_DELAY)-1:0]         o_wp,
    output fcer_pkg::t_tag                       o_tag
);
    import fcer_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);

    logic [SAMPLE_W-1:0] r_mem [MAX_DELAY];

    logic                       r_vld;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [AW-1:0]              r_wp;
    t_tag                       r_tag;
    t_flags                     r_flag;
    logic signed [SAMPLE_W-1:0] r_rd;
    logic signed [SAMPLE_W-1:0] r_fwd;

    logic [AW:0]                w_sum;
    logic [AW-1:0]              w_rd_addr;
    logic signed [SAMPLE_W-1:0] w_prev;
    logic signed [31:0]         w_prod;
    logic signed [31:0]         w_bias;
    logic signed [31:0]         w_quot;
    logic signed [SAMPLE_W-1:0] w_y;

    // circular read address wp - d modulo depth
    always_comb begin
        w_sum = {1'b0, i_wp} + (AW+1)'(MAX_DELAY) - (AW+1)'(i_delay);
        if (w_sum >= (AW+1)'(MAX_DELAY)) begin
            w_rd_addr = AW'(w_sum - (AW+1)'(MAX_DELAY));
        end else begin
            w_rd_addr = w_sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    // read-before-write: a delay of one is served from r_fwd instead
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x    <= i_x;
            r_wp   <= i_wp;
            r_tag  <= i_tag;
            r_flag <= i_flag;
            r_rd   <= $signed(r_mem[w_rd_addr]);
            if (r_vld) begin
                r_mem[r_wp] <= w_y;
                r_fwd       <= w_y;
            end
        end
    end

    always_comb begin
        if (r_flag.zero) begin
            w_prev = r_x;
        end else if (r_flag.one) begin
            w_prev = r_fwd;
        end else begin
            w_prev = r_rd;
        end
        w_prod = w_prev * i_gain;
        // divide by 2^15 rounding toward zero
        w_bias = w_prod + 32'sd32767;
        w_quot = w_prod[31] ? (w_bias >>> 15) : (w_prod >>> 15);
        w_y    = r_flag.bypass ? r_x : (r_x + $signed(w_quot[SAMPLE_W-1:0]));
    end

    assign o_vld = r_vld;
    assign o_y   = w_y;
    assign o_wp  = r_wp;
    assign o_tag = r_tag;

endmodule

// ===== rtl/feedback_comb_echo_reverb_core.sv =====
// feedback_comb_echo_reverb_core: top level; one word in, one word out per cycle unless stalled
// stages: two front stages, then one comb stage after another, then the output register
// throughput: one word per cycle unless the output stalls, set by the simple dual-port
// history rams (one read, one write)
// reset: synchronous active low; registers return to defaults, history rams are not cleared
// depends on fcer_pkg, fcer_delay_unit, fcer_comb_stage
`timescale 1ns / 1ps

module feedback_comb_echo_reverb_core #(
    parameter int unsigned MAX_DELAY = fcer_pkg::MAX_DELAY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [fcer_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fcer_pkg::CFG_W-1:0]           i_cfg_wdata,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [fcer_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_last_of_buffer,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [fcer_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_last_out
);
    import fcer_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int DW = $clog2(MAX_DELAY + 1);

    // live config and per-stage delays in samples
    t_cfg                        w_cfg;
    logic [N_STAGES-1:0][DW-1:0] w_delay;

    // whole pipeline moves in lockstep; it stalls only when the output
    // register is held and the last comb stage has a word waiting
    logic w_adv;
    logic w_accept;

    // word counters: ram write slot and position within the buffer
    logic [AW-1:0] r_wp;
    logic [AW-1:0] n_wp;
    logic [DW-1:0] r_pos;
    logic [DW-1:0] n_pos;

    // front stage a: word as accepted
    logic                       r_a_vld;
    logic signed [SAMPLE_W-1:0] r_a_x;
    logic                       r_a_last;
    logic [AW-1:0]              r_a_wp;
    logic [DW-1:0]              r_a_pos;

    // front stage b: delays are settled here, flags get decided
    logic                       r_b_vld;
    logic signed [SAMPLE_W-1:0] r_b_x;
    logic                       r_b_last;
    logic [AW-1:0]              r_b_wp;
    logic [DW-1:0]              r_b_pos;

    // comb chain, index 0 feeds the first stage
    logic                                   w_vld [N_STAGES+1];
    logic signed [SAMPLE_W-1:0]             w_x   [N_STAGES+1];
    logic [AW-1:0]                          w_wp  [N_STAGES+1];
    t_tag                                   w_tag [N_STAGES+1];
    logic signed [N_STAGES-1:0][SAMPLE_W-1:0] w_gain;

    // output register
    logic                       r_o_vld;
    logic signed [SAMPLE_W-1:0] r_o_y;
    logic                       r_o_last;

    fcer_delay_unit #(
        .MAX_DELAY (MAX_DELAY)
    ) u_delay (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg),
        .o_delay     (w_delay)
    );

    assign w_adv      = !w_vld[N_STAGES] || !r_o_vld || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    // next write slot wraps at depth; position restarts after a last word, else saturates at depth
    always_comb begin
        n_wp = (r_wp == AW'(MAX_DELAY - 1)) ? '0 : (r_wp + 1'b1);
        if (i_last_of_buffer) begin
            n_pos = '0;
        end else if (r_pos < DW'(MAX_DELAY)) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_pos <= '0;
        end else if (w_accept) begin
            r_wp  <= n_wp;
            r_pos <= n_pos;
        end
    end

    // front stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= w_accept;
            r_b_vld <= r_a_vld;
        end
    end

    // front stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_x    <= i_sample_in;
            r_a_last <= i_last_of_buffer;
            r_a_wp   <= r_wp;
            r_a_pos  <= r_pos;
            r_b_x    <= r_a_x;
            r_b_last <= r_a_last;
            r_b_wp   <= r_a_wp;
            r_b_pos  <= r_a_pos;
        end
    end

    // decide bypass for every stage from the position in the buffer, and the
    // feedback source from its delay; stages two and three pass through in echo mode
    always_comb begin
        w_vld[0]      = r_b_vld;
        w_x[0]        = r_b_x;
        w_wp[0]       = r_b_wp;
        w_tag[0].last = r_b_last;
        for (int k = 0; k < N_STAGES; k++) begin
            w_tag[0].flags[k].bypass = (r_b_pos < w_delay[k]) ||
                                       ((k != 0) && (w_cfg.mode == MODE_ECHO));
            w_tag[0].flags[k].zero   = (w_delay[k] == '0);
            w_tag[0].flags[k].one    = (w_delay[k] == DW'(1));
        end
    end

    // stage gains: echo gain from the register, reverb gains fixed
    always_comb begin
        w_gain[0] = (w_cfg.mode == MODE_REVERB) ? REV_GAIN_1 : w_cfg.gain;
        w_gain[1] = REV_GAIN_2;
        w_gain[2] = REV_GAIN_3;
    end

    for (genvar k = 0; k < N_STAGES; k++) begin : g_stage
        fcer_comb_stage #(
            .MAX_DELAY (MAX_DELAY)
        ) u_comb (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[k]),
            .i_x     (w_x[k]),
            .i_wp    (w_wp[k]),
            .i_tag   (w_tag[k]),
            .i_flag  (w_tag[k].flags[k]),
            .i_delay (w_delay[k]),
            .i_gain  (w_gain[k]),
            .o_vld   (w_vld[k+1]),
            .o_y     (w_x[k+1]),
            .o_wp    (w_wp[k+1]),
            .o_tag   (w_tag[k+1])
        );
    end

    // output register loads whenever it is free or being drained; if the
    // pipeline advanced past an empty last stage while held, it keeps its word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (!r_o_vld || i_out_ready) begin
            r_o_vld <= w_vld[N_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || i_out_ready) begin
            r_o_y    <= w_x[N_STAGES];
            r_o_last <= w_tag[N_STAGES].last;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_sample_out = r_o_y;
    assign o_last_out   = r_o_last;

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for feedback_comb_echo_reverb_core, echo and reverb modes
// depends on fcer_pkg and the rtl of the core; a directed table first, then random buffers
`timescale 1ns / 1ps

module tb_top;

    import fcer_pkg::*;

    // history depth of the bench copy, same as the core default
    localparam int unsigned HIST_DEPTH   = MAX_DELAY_DEF;
    // fixed reverb cascade: delay in ms and Q1.15 gain per stage
    localparam int unsigned REVERB_MS_A  = 50;
    localparam int unsigned REVERB_MS_B  = 100;
    localparam int unsigned REVERB_MS_C  = 150;
    localparam int          REVERB_G_A   = 9830;
    localparam int          REVERB_G_B   = 6554;
    localparam int          REVERB_G_C   = 3277;
    // pacing and run length
    localparam int          MAX_GAP      = 12;
    localparam int          HOLD_AT_WORD = 500;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          RANDOM_WORDS = 1424;
    localparam int          PHASE_WORDS  = 100;

    typedef enum logic {
        ROW_SET  = 1'b0,
        ROW_WORD = 1'b1
    } t_row_kind;

    // one row of the directed table: a register set or one sample word
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] f0;    // mode or sample
        logic [15:0] f1;    // echo delay in ms
        logic [15:0] f2;    // sample rate
        logic [15:0] f3;    // echo gain
        logic        last;
        logic        typed; // want holds a hand-written expectation
        logic [15:0] want;
    } t_row;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_word;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in;
    logic                       i_last_of_buffer;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_last_out;

    // bench copy of the registers and the comb state
    t_mode              model_mode     = MODE_ECHO;
    logic [9:0]         model_delay_ms = 10'd50;
    logic [15:0]        model_rate     = 16'd44100;
    logic signed [15:0] model_gain     = 16'sd9830;
    logic [15:0]        comb_hist [3][HIST_DEPTH];
    int unsigned        buf_pos        = 0;
    int unsigned        wr_ptr         = 0;

    // processed words still to come out of the core, oldest first
    t_word processed_words [$];
    t_row  stim_rows [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;   // no idling on either side in this phase
    bit hold_req     = 1'b0;   // sender asks the receiver for the long hold-off

    feedback_comb_echo_reverb_core #(
        .MAX_DELAY(HIST_DEPTH)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_in      (i_sample_in),
        .i_last_of_buffer (i_last_of_buffer),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_sample_out     (o_sample_out),
        .o_last_out       (o_last_out)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // ms to samples at the current rate, clamped to the history depth
    function automatic int unsigned ms_to_samples(int unsigned ms);
        int unsigned d;
        d = ms * model_rate / 1000;
        return (d > HIST_DEPTH) ? HIST_DEPTH : d;
    endfunction

    // one recursive comb: x plus the delayed output times gain, truncated toward zero
    function automatic logic [15:0] comb_stage(int st, logic [15:0] x, int unsigned d,
                                               int gain);
        logic [15:0] prev;
        int          prod;
        if (buf_pos < d)
            return x;
        // zero delay feeds back the stage input itself
        prev = (d == 0) ? x : comb_hist[st][(wr_ptr + HIST_DEPTH - d) % HIST_DEPTH];
        prod = int'($signed(prev)) * gain;
        prod = prod / 32768;
        return x + prod[15:0];
    endfunction

    // advance the bench copy by one sample and return the processed sample
    function automatic logic [15:0] process_sample(logic [15:0] x, logic last);
        logic [15:0] s1;
        logic [15:0] s2;
        logic [15:0] s3;
        if (model_mode == MODE_ECHO) begin
            s1 = comb_stage(0, x, ms_to_samples(model_delay_ms), int'(model_gain));
            s2 = s1;
            s3 = s1;
        end else begin
            s1 = comb_stage(0, x,  ms_to_samples(REVERB_MS_A), REVERB_G_A);
            s2 = comb_stage(1, s1, ms_to_samples(REVERB_MS_B), REVERB_G_B);
            s3 = comb_stage(2, s2, ms_to_samples(REVERB_MS_C), REVERB_G_C);
        end
        comb_hist[0][wr_ptr] = s1;
        comb_hist[1][wr_ptr] = s2;
        comb_hist[2][wr_ptr] = s3;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        // a new buffer restarts the position, otherwise it saturates at the depth
        if (last)
            buf_pos = 0;
        else if (buf_pos < HIST_DEPTH)
            buf_pos++;
        return s3;
    endfunction

    function automatic t_row cfg_row(t_mode mode, logic [15:0] ms, logic [15:0] rate,
                                     logic [15:0] gain);
        return '{kind: ROW_SET, f0: {15'd0, mode}, f1: ms, f2: rate, f3: gain,
                 last: 1'b0, typed: 1'b0, want: 16'd0};
    endfunction

    function automatic t_row word_row(logic [15:0] sample, logic last, logic typed,
                                      logic [15:0] want);
        return '{kind: ROW_WORD, f0: sample, f1: 16'd0, f2: 16'd0, f3: 16'd0,
                 last: last, typed: typed, want: want};
    endfunction

    // mostly full-range samples, with the extremes and values near zero mixed in
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
        $display("mismatch %0d: %s want %h got %h at %0t", mismatches, what, want,
                 got, $realtime);
        mismatches++;
    endtask

    // offer one word after a random gap (none in a steady phase) and hold it until accepted
    task automatic send_word(logic [15:0] sample, logic last, logic typed,
                             logic [15:0] want);
        int    gap;
        t_word w;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_sample_in      <= sample;
        i_last_of_buffer <= last;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        w.sample = process_sample(sample, last);
        if (typed)
            w.sample = want;
        w.last = last;
        processed_words.push_back(w);
    endtask

    // stop offering and wait until every processed word has come out
    task automatic drain_outputs();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (processed_words.size() != 0) @(posedge i_clk);
    endtask

    // write all four registers back to back, core idle
    task automatic apply_settings(t_mode mode, logic [15:0] ms, logic [15:0] rate,
                                  logic [15:0] gain);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_wdata <= {15'd0, mode};
        @(negedge i_clk);
        i_cfg_index <= CFG_DELAY;
        i_cfg_wdata <= ms;
        @(negedge i_clk);
        i_cfg_index <= CFG_RATE;
        i_cfg_wdata <= rate;
        @(negedge i_clk);
        i_cfg_index <= CFG_GAIN;
        i_cfg_wdata <= gain;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_mode     = mode;
        model_delay_ms = ms[9:0];
        model_rate     = rate;
        model_gain     = gain;
    endtask

    // output side: random ready gaps, one long hold-off, field by field check
    initial begin : output_side
        int    gap;
        t_word want;
        forever begin
            @(negedge i_clk);
            // long hold-off so the pipeline fills and back-pressures the input
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (processed_words.size() == 0) begin
                flag_mismatch("word with nothing pending", 16'd0, o_sample_out);
            end else begin
                want = processed_words.pop_front();
                if (o_sample_out !== want.sample)
                    flag_mismatch("sample_out", want.sample, o_sample_out);
                if (o_last_out !== want.last)
                    flag_mismatch("last_out", {15'd0, want.last}, {15'd0, o_last_out});
            end
        end
    end

    // watchdog: cycles in a row with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int          random_words;
        int          phase_words;
        int          buf_len;
        int unsigned span;
        t_mode       new_mode;
        logic [15:0] new_rate;
        logic [15:0] new_gain;
        logic [15:0] new_ms;
        bit          hold_asked;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_MODE;
        i_cfg_wdata      = '0;
        i_in_valid       = 1'b0;
        i_sample_in      = '0;
        i_last_of_buffer = 1'b0;
        i_out_ready      = 1'b0;
        random_words     = 0;
        hold_asked       = 1'b0;

        // reset defaults: 2205-sample echo delay, so a short buffer passes unchanged
        stim_rows.push_back(word_row(16'h0000, 1'b0, 1'b1, 16'h0000));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b1, 16'h7FFF));
        stim_rows.push_back(word_row(16'h8000, 1'b0, 1'b1, 16'h8000));
        stim_rows.push_back(word_row(16'h0001, 1'b0, 1'b1, 16'h0001));
        stim_rows.push_back(word_row(16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
        // zero delay, most negative gain: the one overflowing quotient
        stim_rows.push_back(cfg_row(MODE_ECHO, 16'd0, 16'd44100, 16'h8000));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h8000, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h1234, 1'b1, 1'b0, 16'd0));
        // zero delay, most positive gain: sum wraps
        stim_rows.push_back(cfg_row(MODE_ECHO, 16'd0, 16'd44100, 16'h7FFF));
        stim_rows.push_back(word_row(16'h8000, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h7FFF, 1'b1, 1'b0, 16'd0));
        // one-sample delay, full feedback
        stim_rows.push_back(cfg_row(MODE_ECHO, 16'd1, 16'd1000, 16'h7FFF));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h8000, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h8000, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h0064, 1'b1, 1'b0, 16'd0));
        // longest delay, clamped to the depth: all pass through
        stim_rows.push_back(cfg_row(MODE_ECHO, 16'd1000, 16'd48000, 16'h8000));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b1, 16'h7FFF));
        stim_rows.push_back(word_row(16'h8000, 1'b1, 1'b1, 16'h8000));
        // reverb at a low rate: stage delays of 1, 2 and 3
        stim_rows.push_back(cfg_row(MODE_REVERB, 16'd1000, 16'd20, 16'h0000));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h8000, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h8000, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h03E8, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h0000, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h0000, 1'b1, 1'b0, 16'd0));
        // reverb with every stage delay at zero
        stim_rows.push_back(cfg_row(MODE_REVERB, 16'd0, 16'd1, 16'h0000));
        stim_rows.push_back(word_row(16'h7FFF, 1'b0, 1'b0, 16'd0));
        stim_rows.push_back(word_row(16'h8000, 1'b1, 1'b0, 16'd0));

        // synchronous reset, held low over rising edges and released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_SET) begin
                drain_outputs();
                apply_settings(t_mode'(stim_rows[r].f0[0]), stim_rows[r].f1,
                               stim_rows[r].f2, stim_rows[r].f3);
            end else begin
                send_word(stim_rows[r].f0, stim_rows[r].last, stim_rows[r].typed,
                          stim_rows[r].want);
            end
        end

        // random phases: new settings, then whole buffers, each ending on a last word
        while (random_words < RANDOM_WORDS) begin
            drain_outputs();
            new_mode = t_mode'($urandom_range(0, 1));
            // low rates keep delays short enough for buffers to run past them
            case ($urandom_range(0, 7))
                0, 1:    new_rate = 16'($urandom_range(1000, 48000));
                2:       new_rate = 16'($urandom_range(201, 1000));
                default: new_rate = 16'($urandom_range(1, 200));
            endcase
            new_ms = 16'($urandom_range(0, 1000));
            case ($urandom_range(0, 5))
                0:       new_gain = 16'h8000;
                1:       new_gain = 16'h7FFF;
                2:       new_gain = 16'h0000;
                default: new_gain = 16'($urandom);
            endcase
            apply_settings(new_mode, new_ms, new_rate, new_gain);
            steady = ($urandom_range(0, 3) == 0);
            // ask for the long hold-off while a whole phase is still to be sent
            if (!hold_asked && random_words >= HOLD_AT_WORD) begin
                hold_req   = 1'b1;
                hold_asked = 1'b1;
            end
            span = (new_mode == MODE_ECHO) ? ms_to_samples(new_ms)
                                           : ms_to_samples(REVERB_MS_C);
            phase_words = 0;
            while (phase_words < PHASE_WORDS && random_words < RANDOM_WORDS) begin
                // short delays: most buffers reach past the delay, a few are short noise; long delays: short buffers
                if (span > 300)
                    buf_len = $urandom_range(1, 40);
                else if ($urandom_range(0, 4) == 0)
                    buf_len = $urandom_range(1, 8);
                else
                    buf_len = span + $urandom_range(1, 60);
                // the last buffer is cut so the run ends on the word count
                if (buf_len > RANDOM_WORDS - random_words)
                    buf_len = RANDOM_WORDS - random_words;
                for (int j = 0; j < buf_len; j++) begin
                    send_word(pick_sample(), (j == buf_len - 1), 1'b0, 16'd0);
                    phase_words++;
                    random_words++;
                end
            end
        end

        drain_outputs();
        steady = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fcer_pkg.sv
rtl/fcer_delay_unit.sv
rtl/fcer_comb_stage.sv
rtl/feedback_comb_echo_reverb_core.sv
bench/tb_top.sv
